// ----- hdl/fsr_pkg.sv -----
package fsr_pkg;

	localparam int SCREEN_WIDTH_DEF  = 128;
	localparam int SCREEN_HEIGHT_DEF = 64;
	localparam int STORE_DEPTH       = 1024;
	localparam int ADDR_W            = $clog2(STORE_DEPTH);
	localparam int IDX_W             = 15;
	localparam int D_W               = 12;
	localparam int C_W               = 10;

	typedef enum logic [2:0] {
		CMD_CLEAR,
		CMD_PIXEL,
		CMD_LINE,
		CMD_RECT,
		CMD_FILL_RECT,
		CMD_CIRCLE,
		CMD_FILL_CIRCLE,
		CMD_READ
	} cmd_t;

	typedef enum logic [1:0] {
		SOP_PLOT,
		SOP_CLEAR,
		SOP_READ
	} sop_t;

	typedef enum logic [1:0] {
		ST_CLR,
		ST_IDLE,
		ST_RMW
	} store_state_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ISSUE,
		S_LOAD,
		S_LINE,
		S_NEXT,
		S_CIRC,
		S_CPLOT,
		S_CUPD,
		S_WAIT,
		S_DONE
	} seq_state_t;

	typedef struct packed {
		logic              valid;
		sop_t              op;
		logic [7:0]        x;
		logic [7:0]        y;
		logic [ADDR_W-1:0] index;
	} store_req_t;

	typedef struct packed {
		logic       ready;
		logic [7:0] rd_data;
	} store_stat_t;

	typedef struct packed {
		logic       load;
		logic       adv;
		logic [7:0] ax;
		logic [7:0] bx;
		logic [7:0] ay;
		logic [7:0] by;
	} line_ctl_t;

	typedef struct packed {
		logic [7:0] x;
		logic [7:0] y;
		logic       last;
	} line_pos_t;

endpackage

// ----- hdl/fsr_if.sv -----
interface fsr_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] cmd;
	logic [7:0] start_x;
	logic [7:0] start_y;
	logic [7:0] end_x;
	logic [7:0] end_y;
	logic [7:0] radius;
	logic [9:0] read_index;

	modport source (output valid, cmd, start_x, start_y, end_x, end_y, radius, read_index,
		input ready);
	modport sink (input valid, cmd, start_x, start_y, end_x, end_y, radius, read_index,
		output ready);
endinterface

interface fsr_rsp_if;
	logic       valid;
	logic       ready;
	logic       status;
	logic [7:0] read_data;

	modport source (output valid, status, read_data, input ready);
	modport sink (input valid, status, read_data, output ready);
endinterface

// ----- hdl/fsr_line.sv -----
module fsr_line (
	input  logic                clk,
	input  fsr_pkg::line_ctl_t  ctl,
	output fsr_pkg::line_pos_t  pos
);

	logic [7:0] x_q, y_q, bx_q, by_q, dx_q, dy_q;
	logic       sx_neg_q, sy_neg_q, steep_q;
	logic signed [fsr_pkg::D_W-1:0] d_q;

	logic signed [8:0] ddx, ddy;
	logic [7:0] adx, ady;
	logic signed [fsr_pkg::D_W-1:0] edx, edy, qdx, qdy, d_init, d_next;
	logic [7:0] x_next, y_next;
	logic step_x, step_y;

	always_comb begin
		ddx = $signed({1'b0, ctl.bx}) - $signed({1'b0, ctl.ax});
		ddy = $signed({1'b0, ctl.by}) - $signed({1'b0, ctl.ay});
		adx = ddx[8] ? 8'(-ddx) : ddx[7:0];
		ady = ddy[8] ? 8'(-ddy) : ddy[7:0];
		edx = $signed(fsr_pkg::D_W'(adx));
		edy = $signed(fsr_pkg::D_W'(ady));
		d_init = (ady < adx) ? (edy <<< 1) - edx : edy - (edx <<< 1);

		qdx = $signed(fsr_pkg::D_W'(dx_q));
		qdy = $signed(fsr_pkg::D_W'(dy_q));
		if (!steep_q) begin
			step_x = 1'b1;
			step_y = (d_q >= 0);
			d_next = d_q + (qdy <<< 1) - (step_y ? (qdx <<< 1) : fsr_pkg::D_W'(0));
		end else begin
			step_y = 1'b1;
			step_x = (d_q <= 0);
			d_next = d_q - (qdx <<< 1) + (step_x ? (qdy <<< 1) : fsr_pkg::D_W'(0));
		end
		x_next = step_x ? (sx_neg_q ? x_q - 8'd1 : x_q + 8'd1) : x_q;
		y_next = step_y ? (sy_neg_q ? y_q - 8'd1 : y_q + 8'd1) : y_q;

		pos.x    = x_q;
		pos.y    = y_q;
		pos.last = steep_q ? (y_q == by_q) : (x_q == bx_q);
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			x_q      <= ctl.ax;
			y_q      <= ctl.ay;
			bx_q     <= ctl.bx;
			by_q     <= ctl.by;
			dx_q     <= adx;
			dy_q     <= ady;
			sx_neg_q <= ddx[8];
			sy_neg_q <= ddy[8];
			steep_q  <= !(ady < adx);
			d_q      <= d_init;
		end else if (ctl.adv) begin
			x_q <= x_next;
			y_q <= y_next;
			d_q <= d_next;
		end
	end

endmodule

// ----- hdl/fsr_store.sv -----
module fsr_store #(
	parameter int SCREEN_WIDTH  = fsr_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = fsr_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fsr_pkg::store_req_t  req,
	output fsr_pkg::store_stat_t stat
);

	logic [7:0] mem [fsr_pkg::STORE_DEPTH];

	fsr_pkg::store_state_t state_q, state_d;
	logic [fsr_pkg::ADDR_W-1:0] clr_cnt_q, addr_q, waddr, raddr;
	logic [7:0] mask_q, rdata_q, wdata;
	logic [fsr_pkg::IDX_W-1:0] idx;
	logic hit, we, re;

	always_comb begin
		idx = fsr_pkg::IDX_W'(req.x)
			+ fsr_pkg::IDX_W'(req.y[7:3]) * fsr_pkg::IDX_W'(SCREEN_WIDTH);
		hit = ({1'b0, req.x} < 9'(SCREEN_WIDTH)) && ({1'b0, req.y} < 9'(SCREEN_HEIGHT))
			&& (idx[fsr_pkg::IDX_W-1:fsr_pkg::ADDR_W] == '0);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fsr_pkg::ST_CLR: begin
				if (clr_cnt_q == '1)
					state_d = fsr_pkg::ST_IDLE;
			end
			fsr_pkg::ST_IDLE: begin
				if (req.valid) begin
					case (req.op)
						fsr_pkg::SOP_PLOT:  if (hit) state_d = fsr_pkg::ST_RMW;
						fsr_pkg::SOP_CLEAR: state_d = fsr_pkg::ST_CLR;
						default:            state_d = fsr_pkg::ST_IDLE;
					endcase
				end
			end
			fsr_pkg::ST_RMW: state_d = fsr_pkg::ST_IDLE;
			default:         state_d = fsr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = addr_q;
		wdata = rdata_q | mask_q;
		raddr = (req.op == fsr_pkg::SOP_READ) ? req.index : idx[fsr_pkg::ADDR_W-1:0];
		unique case (state_q)
			fsr_pkg::ST_CLR: begin
				we    = 1'b1;
				waddr = clr_cnt_q;
				wdata = '0;
			end
			fsr_pkg::ST_IDLE: begin
				re = req.valid && (((req.op == fsr_pkg::SOP_PLOT) && hit)
					|| (req.op == fsr_pkg::SOP_READ));
			end
			fsr_pkg::ST_RMW: we = 1'b1;
			default: ;
		endcase
		stat.ready   = (state_q == fsr_pkg::ST_IDLE);
		stat.rd_data = rdata_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= fsr_pkg::ST_CLR;
			clr_cnt_q <= '0;
		end else begin
			state_q   <= state_d;
			clr_cnt_q <= (state_q == fsr_pkg::ST_CLR) ? clr_cnt_q + 1'b1 : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == fsr_pkg::ST_IDLE) begin
			addr_q <= idx[fsr_pkg::ADDR_W-1:0];
			mask_q <= 8'(1) << req.y[2:0];
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

endmodule

// ----- hdl/page_framebuffer_shape_rasterizer.sv -----
// Page framebuffer shape rasterizer: a 1-bit-per-pixel picture of 1024 bytes (byte = x +
// (y/8)*SCREEN_WIDTH, bit = y%8) held in one single-port synchronous RAM. Each request
// returns one response. Every on-screen pixel is a RAM read, then an OR and write back;
// off-screen pixels do not touch the RAM. A line is loaded into the line stepper, then its
// pixels are plotted; rectangles, filled rectangles and filled circles are drawn as lines,
// circles as points. Clear writes zero to every byte; after reset the same clearing pass
// runs before the first request is taken. The response is registered once the RAM is idle
// again and the response channel is free.
module page_framebuffer_shape_rasterizer #(
	parameter int SCREEN_WIDTH  = fsr_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = fsr_pkg::SCREEN_HEIGHT_DEF
) (
	input logic        clk,
	input logic        arst_n,
	fsr_cmd_if.sink    cmd_chan,
	fsr_rsp_if.source  rsp_chan
);

	fsr_pkg::seq_state_t  state_q, state_d;
	fsr_pkg::cmd_t        cmd_q;
	fsr_pkg::store_req_t  sreq;
	fsr_pkg::store_stat_t sstat;
	fsr_pkg::line_ctl_t   lctl;
	fsr_pkg::line_pos_t   lpos;

	logic [7:0] x1_q, y1_q, x2_q, y2_q, row_q;
	logic [2:0] idx_q;
	logic [fsr_pkg::ADDR_W-1:0] ri_q;
	logic status_q;
	logic signed [fsr_pkg::C_W-1:0] cir_x_q, cir_y_q, cy_a, cx_b;
	logic signed [fsr_pkg::D_W-1:0] err_q, e_a, e_b;
	logic out_valid_q, out_status_q;
	logic [7:0] out_data_q;

	logic accept, can_out;
	fsr_pkg::cmd_t in_cmd;
	logic [7:0] ux, uy, px, py;

	assign in_cmd  = fsr_pkg::cmd_t'(cmd_chan.cmd);
	assign accept  = cmd_chan.valid && cmd_chan.ready;
	assign can_out = !out_valid_q || rsp_chan.ready;
	assign ux      = cir_x_q[7:0];
	assign uy      = cir_y_q[7:0];

	assign rsp_chan.valid     = out_valid_q;
	assign rsp_chan.status    = out_status_q;
	assign rsp_chan.read_data = out_data_q;

	fsr_store #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sreq),
		.stat   (sstat)
	);

	fsr_line u_line (
		.clk (clk),
		.ctl (lctl),
		.pos (lpos)
	);

	// circle step
	always_comb begin
		cy_a = (err_q <= 0) ? cir_y_q + fsr_pkg::C_W'(1) : cir_y_q;
		e_a  = (err_q <= 0) ? err_q + (fsr_pkg::D_W'(cy_a) <<< 1) + fsr_pkg::D_W'(1) : err_q;
		cx_b = (e_a > 0) ? cir_x_q - fsr_pkg::C_W'(1) : cir_x_q;
		e_b  = (e_a > 0) ? e_a - (fsr_pkg::D_W'(cx_b) <<< 1) - fsr_pkg::D_W'(1) : e_a;
	end

	// outline octant points
	always_comb begin
		case (idx_q)
			3'd0: begin px = x1_q + ux; py = y1_q + uy; end
			3'd1: begin px = x1_q + uy; py = y1_q + ux; end
			3'd2: begin px = x1_q - uy; py = y1_q + ux; end
			3'd3: begin px = x1_q - ux; py = y1_q + uy; end
			3'd4: begin px = x1_q - ux; py = y1_q - uy; end
			3'd5: begin px = x1_q - uy; py = y1_q - ux; end
			3'd6: begin px = x1_q + uy; py = y1_q - ux; end
			default: begin px = x1_q + ux; py = y1_q - uy; end
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			fsr_pkg::S_IDLE: begin
				if (accept) begin
					case (in_cmd) inside
						fsr_pkg::CMD_LINE, fsr_pkg::CMD_RECT, fsr_pkg::CMD_FILL_RECT:
							state_d = fsr_pkg::S_LOAD;
						fsr_pkg::CMD_CIRCLE, fsr_pkg::CMD_FILL_CIRCLE:
							state_d = fsr_pkg::S_CIRC;
						default: state_d = fsr_pkg::S_ISSUE;
					endcase
				end
			end
			fsr_pkg::S_ISSUE: if (sstat.ready) state_d = fsr_pkg::S_WAIT;
			fsr_pkg::S_LOAD:  state_d = fsr_pkg::S_LINE;
			fsr_pkg::S_LINE:  if (sstat.ready && lpos.last) state_d = fsr_pkg::S_NEXT;
			fsr_pkg::S_NEXT: begin
				case (cmd_q)
					fsr_pkg::CMD_RECT:
						state_d = (idx_q == 3'd3) ? fsr_pkg::S_WAIT : fsr_pkg::S_LOAD;
					fsr_pkg::CMD_FILL_RECT:
						state_d = (row_q == y2_q) ? fsr_pkg::S_WAIT : fsr_pkg::S_LOAD;
					fsr_pkg::CMD_FILL_CIRCLE:
						state_d = (idx_q == 3'd3) ? fsr_pkg::S_CUPD : fsr_pkg::S_LOAD;
					default: state_d = fsr_pkg::S_WAIT;
				endcase
			end
			fsr_pkg::S_CIRC: begin
				if (cir_x_q >= cir_y_q)
					state_d = (cmd_q == fsr_pkg::CMD_FILL_CIRCLE) ? fsr_pkg::S_LOAD
						: fsr_pkg::S_CPLOT;
				else
					state_d = fsr_pkg::S_WAIT;
			end
			fsr_pkg::S_CPLOT: if (sstat.ready && idx_q == 3'd7) state_d = fsr_pkg::S_CUPD;
			fsr_pkg::S_CUPD:  state_d = fsr_pkg::S_CIRC;
			fsr_pkg::S_WAIT:  if (sstat.ready) state_d = fsr_pkg::S_DONE;
			fsr_pkg::S_DONE:  if (can_out) state_d = fsr_pkg::S_IDLE;
			default:          state_d = fsr_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd_chan.ready = (state_q == fsr_pkg::S_IDLE) && sstat.ready;

		sreq.valid = 1'b0;
		sreq.op    = fsr_pkg::SOP_PLOT;
		sreq.x     = x1_q;
		sreq.y     = y1_q;
		sreq.index = ri_q;

		lctl.load = (state_q == fsr_pkg::S_LOAD);
		lctl.adv  = (state_q == fsr_pkg::S_LINE) && sstat.ready && !lpos.last;
		lctl.ax   = x1_q;
		lctl.bx   = x2_q;
		lctl.ay   = y1_q;
		lctl.by   = y2_q;
		case (cmd_q)
			fsr_pkg::CMD_RECT: begin
				case (idx_q[1:0])
					2'd0: begin lctl.by = y1_q; end
					2'd1: begin lctl.ay = y2_q; end
					2'd2: begin lctl.bx = x1_q; end
					default: begin lctl.ax = x2_q; end
				endcase
			end
			fsr_pkg::CMD_FILL_RECT: begin
				lctl.ay = row_q;
				lctl.by = row_q;
			end
			fsr_pkg::CMD_FILL_CIRCLE: begin
				case (idx_q[1:0])
					2'd0: begin
						lctl.ax = x1_q - ux; lctl.bx = x1_q + ux;
						lctl.ay = y1_q + uy; lctl.by = y1_q + uy;
					end
					2'd1: begin
						lctl.ax = x1_q - ux; lctl.bx = x1_q + ux;
						lctl.ay = y1_q - uy; lctl.by = y1_q - uy;
					end
					2'd2: begin
						lctl.ax = x1_q - uy; lctl.bx = x1_q + uy;
						lctl.ay = y1_q + ux; lctl.by = y1_q + ux;
					end
					default: begin
						lctl.ax = x1_q - uy; lctl.bx = x1_q + uy;
						lctl.ay = y1_q - ux; lctl.by = y1_q - ux;
					end
				endcase
			end
			default: ;
		endcase

		unique case (state_q)
			fsr_pkg::S_ISSUE: begin
				sreq.valid = 1'b1;
				case (cmd_q)
					fsr_pkg::CMD_CLEAR: sreq.op = fsr_pkg::SOP_CLEAR;
					fsr_pkg::CMD_READ:  sreq.op = fsr_pkg::SOP_READ;
					default:            sreq.op = fsr_pkg::SOP_PLOT;
				endcase
			end
			fsr_pkg::S_LINE: begin
				sreq.valid = 1'b1;
				sreq.x     = lpos.x;
				sreq.y     = lpos.y;
			end
			fsr_pkg::S_CPLOT: begin
				sreq.valid = 1'b1;
				sreq.x     = px;
				sreq.y     = py;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= fsr_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == fsr_pkg::S_DONE && can_out)
				out_valid_q <= 1'b1;
			else if (rsp_chan.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			fsr_pkg::S_IDLE: begin
				if (accept) begin
					cmd_q   <= in_cmd;
					x1_q    <= cmd_chan.start_x;
					y1_q    <= cmd_chan.start_y;
					x2_q    <= cmd_chan.end_x;
					y2_q    <= cmd_chan.end_y;
					row_q   <= cmd_chan.start_y;
					if (in_cmd == fsr_pkg::CMD_FILL_RECT) begin
						if (cmd_chan.start_x > cmd_chan.end_x) begin
							x1_q <= cmd_chan.end_x;
							x2_q <= cmd_chan.start_x;
						end
						if (cmd_chan.start_y > cmd_chan.end_y) begin
							y1_q  <= cmd_chan.end_y;
							y2_q  <= cmd_chan.start_y;
							row_q <= cmd_chan.end_y;
						end
					end
					idx_q    <= '0;
					ri_q     <= cmd_chan.read_index;
					status_q <= (in_cmd == fsr_pkg::CMD_PIXEL)
						&& (({1'b0, cmd_chan.start_x} >= 9'(SCREEN_WIDTH))
						|| ({1'b0, cmd_chan.start_y} >= 9'(SCREEN_HEIGHT)));
					cir_x_q  <= $signed(fsr_pkg::C_W'(cmd_chan.radius));
					cir_y_q  <= '0;
					err_q    <= '0;
				end
			end
			fsr_pkg::S_NEXT: begin
				idx_q <= idx_q + 3'd1;
				row_q <= row_q + 8'd1;
			end
			fsr_pkg::S_CIRC:  idx_q <= '0;
			fsr_pkg::S_CPLOT: if (sstat.ready) idx_q <= idx_q + 3'd1;
			fsr_pkg::S_CUPD: begin
				cir_x_q <= cx_b;
				cir_y_q <= cy_a;
				err_q   <= e_b;
			end
			fsr_pkg::S_DONE: begin
				if (can_out) begin
					out_status_q <= status_q;
					out_data_q   <= (cmd_q == fsr_pkg::CMD_READ) ? sstat.rd_data : 8'd0;
				end
			end
			default: ;
		endcase
	end

endmodule

// ----- hdl/fsr_checker.sv -----
module fsr_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       rsp_status,
	input logic [7:0] rsp_read_data
);

	logic [1:0] pend_q;
	logic cmd_acc, rsp_acc;

	assign cmd_acc = cmd_valid && cmd_ready;
	assign rsp_acc = rsp_valid && rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pend_q <= '0;
		else
			pend_q <= pend_q + 2'(cmd_acc) - 2'(rsp_acc);
	end

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_read_data))
		else $error("response dropped or changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc |=> !cmd_acc)
		else $error("request accepted while previous one still running");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("response without an outstanding request");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("more than two requests outstanding");

endmodule

bind page_framebuffer_shape_rasterizer fsr_checker u_fsr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd_chan.valid),
	.cmd_ready     (cmd_chan.ready),
	.rsp_valid     (rsp_chan.valid),
	.rsp_ready     (rsp_chan.ready),
	.rsp_status    (rsp_chan.status),
	.rsp_read_data (rsp_chan.read_data)
);

// ----- bench/page_framebuffer_shape_rasterizer_test.sv -----
`timescale 1ns / 100ps

module page_framebuffer_shape_rasterizer_test;

	localparam int WIDTH = fsr_pkg::SCREEN_WIDTH_DEF;
	localparam int HEIGHT = fsr_pkg::SCREEN_HEIGHT_DEF;
	localparam longint CYCLE_LIMIT = 64'd60_000_000;

	typedef struct packed {
		logic       status;
		logic [7:0] read_data;
	} rsp_t;

	logic clk;
	logic arst_n;
	fsr_cmd_if cmd_chan();
	fsr_rsp_if rsp_chan();

	page_framebuffer_shape_rasterizer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_chan(cmd_chan.sink),
		.rsp_chan(rsp_chan.source)
	);

	logic [7:0] shadow_frame [fsr_pkg::STORE_DEPTH];
	rsp_t expected_rsps [$];
	int error_count;
	longint cycle_count;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_off_cycles;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// shadow rasterizer
	function automatic void put_pixel(input int px, input int py, output bit on_screen);
		int idx;
		px = px & 8'hff;
		py = py & 8'hff;
		on_screen = 1'b0;
		if (px >= WIDTH || py >= HEIGHT)
			return;
		on_screen = 1'b1;
		idx = px + (py >> 3) * WIDTH;
		if (idx < fsr_pkg::STORE_DEPTH)
			shadow_frame[idx] = shadow_frame[idx] | (8'd1 << (py & 7));
	endfunction

	function automatic void put_line(input int ax, input int bx, input int ay, input int by);
		int dx;
		int dy;
		int sx;
		int sy;
		int d;
		bit dummy;
		ax &= 255; bx &= 255; ay &= 255; by &= 255;
		dx = bx - ax;
		dy = by - ay;
		sx = 1;
		sy = 1;
		if (dx < 0) begin dx = -dx; sx = -1; end
		if (dy < 0) begin dy = -dy; sy = -1; end
		put_pixel(ax, ay, dummy);
		if (dy < dx) begin
			d = 2 * dy - dx;
			while (ax != bx) begin
				ax = (ax + sx) & 255;
				if (d >= 0) begin
					ay = (ay + sy) & 255;
					d -= 2 * dx;
				end
				d += 2 * dy;
				put_pixel(ax, ay, dummy);
			end
		end else begin
			d = dy - 2 * dx;
			while (ay != by) begin
				ay = (ay + sy) & 255;
				if (d <= 0) begin
					ax = (ax + sx) & 255;
					d += 2 * dy;
				end
				d -= 2 * dx;
				put_pixel(ax, ay, dummy);
			end
		end
	endfunction

	function automatic void put_circle(input int cx, input int cy, input int r, input bit fill);
		int x;
		int y;
		int err;
		bit dummy;
		x = r & 255;
		y = 0;
		err = 0;
		while (x >= y) begin
			if (fill) begin
				put_line(cx - x, cx + x, cy + y, cy + y);
				put_line(cx - x, cx + x, cy - y, cy - y);
				put_line(cx - y, cx + y, cy + x, cy + x);
				put_line(cx - y, cx + y, cy - x, cy - x);
			end else begin
				put_pixel(cx + x, cy + y, dummy);
				put_pixel(cx + y, cy + x, dummy);
				put_pixel(cx - y, cy + x, dummy);
				put_pixel(cx - x, cy + y, dummy);
				put_pixel(cx - x, cy - y, dummy);
				put_pixel(cx - y, cy - x, dummy);
				put_pixel(cx + y, cy - x, dummy);
				put_pixel(cx + x, cy - y, dummy);
			end
			if (err <= 0) begin
				y += 1;
				err += 2 * y + 1;
			end
			if (err > 0) begin
				x -= 1;
				err -= 2 * x + 1;
			end
		end
	endfunction

	function automatic rsp_t predict_rsp(input fsr_pkg::cmd_t cmd, input int x1, input int y1,
			input int x2, input int y2, input int r, input int ri);
		rsp_t res;
		bit on_screen;
		int t;
		res = '0;
		case (cmd)
			fsr_pkg::CMD_CLEAR: begin
				foreach (shadow_frame[i])
					shadow_frame[i] = '0;
			end
			fsr_pkg::CMD_PIXEL: begin
				put_pixel(x1, y1, on_screen);
				res.status = !on_screen;
			end
			fsr_pkg::CMD_LINE: put_line(x1, x2, y1, y2);
			fsr_pkg::CMD_RECT: begin
				put_line(x1, x2, y1, y1);
				put_line(x1, x2, y2, y2);
				put_line(x1, x1, y1, y2);
				put_line(x2, x2, y1, y2);
			end
			fsr_pkg::CMD_FILL_RECT: begin
				if (x1 > x2) begin t = x1; x1 = x2; x2 = t; end
				if (y1 > y2) begin t = y1; y1 = y2; y2 = t; end
				for (int row = y1; row <= y2; row++)
					put_line(x1, x2, row, row);
			end
			fsr_pkg::CMD_CIRCLE: put_circle(x1, y1, r, 1'b0);
			fsr_pkg::CMD_FILL_CIRCLE: put_circle(x1, y1, r, 1'b1);
			default: res.read_data = shadow_frame[ri];
		endcase
		return res;
	endfunction

	task automatic send_request(input fsr_pkg::cmd_t cmd, input int x1, input int y1,
			input int x2, input int y2, input int r, input int ri);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_chan.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_chan.valid <= 1'b1;
		cmd_chan.cmd <= cmd;
		cmd_chan.start_x <= x1[7:0];
		cmd_chan.start_y <= y1[7:0];
		cmd_chan.end_x <= x2[7:0];
		cmd_chan.end_y <= y2[7:0];
		cmd_chan.radius <= r[7:0];
		cmd_chan.read_index <= ri[9:0];
		@(posedge clk);
		while (!cmd_chan.ready)
			@(posedge clk);
		expected_rsps.push_back(predict_rsp(cmd, x1 & 255, y1 & 255, x2 & 255, y2 & 255,
			r & 255, ri & 1023));
		@(negedge clk);
	endtask

	task automatic wait_drained();
		cmd_chan.valid <= 1'b0;
		while (expected_rsps.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic send_random(input int n);
		fsr_pkg::cmd_t cmd;
		int sel;
		int r;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			if (sel < 3) cmd = fsr_pkg::CMD_CLEAR;
			else if (sel < 25) cmd = fsr_pkg::CMD_PIXEL;
			else if (sel < 40) cmd = fsr_pkg::CMD_LINE;
			else if (sel < 48) cmd = fsr_pkg::CMD_RECT;
			else if (sel < 53) cmd = fsr_pkg::CMD_FILL_RECT;
			else if (sel < 62) cmd = fsr_pkg::CMD_CIRCLE;
			else if (sel < 66) cmd = fsr_pkg::CMD_FILL_CIRCLE;
			else cmd = fsr_pkg::CMD_READ;
			// radius mostly small, some full range
			r = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(20);
			if (cmd == fsr_pkg::CMD_FILL_RECT && $urandom_range(3) != 0)
				send_request(cmd, $urandom_range(140), $urandom_range(70),
					$urandom_range(140), $urandom_range(70), r, $urandom_range(1023));
			else if (cmd == fsr_pkg::CMD_PIXEL && $urandom_range(3) != 0)
				send_request(cmd, $urandom_range(WIDTH - 1), $urandom_range(HEIGHT - 1),
					$urandom, $urandom, $urandom, $urandom);
			else
				send_request(cmd, $urandom, $urandom, $urandom, $urandom, r, $urandom);
		end
	endtask

	task automatic test_directed();
		send_request(fsr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0);
		send_request(fsr_pkg::CMD_PIXEL, 0, 0, 0, 0, 0, 0);
		send_request(fsr_pkg::CMD_PIXEL, WIDTH - 1, HEIGHT - 1, 255, 255, 255, 1023);
		send_request(fsr_pkg::CMD_PIXEL, WIDTH, 5, 0, 0, 0, 0);
		send_request(fsr_pkg::CMD_PIXEL, 5, HEIGHT, 0, 0, 0, 0);
		send_request(fsr_pkg::CMD_PIXEL, 255, 255, 0, 0, 0, 0);
		send_request(fsr_pkg::CMD_READ, 0, 0, 0, 0, 0, 1023);
		send_request(fsr_pkg::CMD_LINE, 2, 3, 40, 10, 0, 0);
		send_request(fsr_pkg::CMD_LINE, 10, 50, 14, 2, 0, 0);
		send_request(fsr_pkg::CMD_LINE, 250, 5, 10, 5, 0, 0);
		send_request(fsr_pkg::CMD_LINE, 20, 20, 20, 20, 0, 0);
		send_request(fsr_pkg::CMD_RECT, 100, 60, 130, 10, 0, 0);
		send_request(fsr_pkg::CMD_FILL_RECT, 126, 250, 120, 255, 0, 0);
		send_request(fsr_pkg::CMD_FILL_RECT, 30, 40, 20, 30, 0, 0);
		send_request(fsr_pkg::CMD_CIRCLE, 64, 32, 20, 0, 0, 0);
		send_request(fsr_pkg::CMD_CIRCLE, 0, 0, 255, 0, 0, 0);
		send_request(fsr_pkg::CMD_FILL_CIRCLE, 2, 62, 6, 0, 0, 0);
		send_request(fsr_pkg::CMD_FILL_CIRCLE, 64, 32, 0, 0, 0, 0);
		for (int i = 0; i < 6; i++)
			send_request(fsr_pkg::CMD_READ, 0, 0, 0, 0, 0, $urandom_range(1023));
		send_request(fsr_pkg::CMD_CLEAR, 255, 255, 255, 255, 255, 1023);
		send_request(fsr_pkg::CMD_READ, 0, 0, 0, 0, 0, 0);
		wait_drained();
	endtask

	task automatic test_backpressure();
		fork
			hold_off_cycles = 300;
			for (int i = 0; i < 8; i++)
				send_request(fsr_pkg::CMD_PIXEL, $urandom_range(WIDTH - 1),
					$urandom_range(HEIGHT - 1), 0, 0, 0, 0);
		join
		wait_drained();
	endtask

	task automatic test_random();
		send_idle_pct = 10;
		recv_idle_pct = 59;
		send_random(400);
		wait_drained();
		send_idle_pct = 59;
		recv_idle_pct = 10;
		send_random(400);
		wait_drained();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random(400);
		wait_drained();
	endtask

	// response side
	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			rsp_chan.ready <= 1'b0;
		end else begin
			rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_chan.valid && rsp_chan.ready) begin
			if (expected_rsps.size() == 0) begin
				$display("%0t: unexpected response status=%0d read_data=%02h", $time,
					rsp_chan.status, rsp_chan.read_data);
				error_count++;
			end else begin
				want = expected_rsps.pop_front();
				if (rsp_chan.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status,
						rsp_chan.status);
					error_count++;
				end
				if (rsp_chan.read_data !== want.read_data) begin
					$display("%0t: read_data expected %02h actual %02h", $time,
						want.read_data, rsp_chan.read_data);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL page_framebuffer_shape_rasterizer");
			$finish;
		end
	end

	initial begin
		error_count = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_off_cycles = 0;
		foreach (shadow_frame[i])
			shadow_frame[i] = '0;
		arst_n = 1'b0;
		cmd_chan.valid = 1'b0;
		cmd_chan.cmd = fsr_pkg::CMD_CLEAR;
		cmd_chan.start_x = '0;
		cmd_chan.start_y = '0;
		cmd_chan.end_x = '0;
		cmd_chan.end_y = '0;
		cmd_chan.radius = '0;
		cmd_chan.read_index = '0;
		rsp_chan.ready = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_backpressure();
		test_random();
		if (expected_rsps.size() != 0) begin
			$display("%0t: %0d responses never arrived", $time, expected_rsps.size());
			error_count++;
		end
		if (error_count == 0)
			$display("PASS page_framebuffer_shape_rasterizer");
		else
			$display("FAIL page_framebuffer_shape_rasterizer");
		$finish;
	end

endmodule
